>>> rtl/grid_raycast_column_top_macros.svh
// Assertion macros shared by the raycaster checker.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef GRID_RAYCAST_COLUMN_TOP_MACROS_SVH
`define GRID_RAYCAST_COLUMN_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GRC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GRC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/grc_pkg.sv
// Package for the grid raycaster: field widths, register indexes and the
// command and status structs between controller and datapath. No dependencies.
package grc_pkg;

    localparam int COL_W     = 10;
    localparam int CELL_W    = 6;
    localparam int KIND_W    = 8;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int GRID_W    = 7;
    // Signed cell index: holds -512 up to 511, so -1 up to 64 and every camera cell.
    localparam int MXW       = 10;

    localparam logic [CFG_IDX_W-1:0] REG_CAMERA_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAMERA_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_DIR_X  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_DIR_Y  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CAM_PLANE_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CAM_PLANE_Y = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 3'd7;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_CAST  = 1'b1;

    localparam logic [KIND_W-1:0] KIND_RED   = 8'd1;
    localparam logic [KIND_W-1:0] KIND_GREEN = 8'd2;
    localparam logic [KIND_W-1:0] KIND_BLUE  = 8'd3;

    typedef struct packed {
        logic clr;
        logic ld_in;
        logic ray_mul;
        logic ray_sum;
        logic walk_init;
        logic pq_mul;
        logic step;
        logic look;
        logic nowall_set;
        logic div_mul;
        logic div_chk;
        logic div_iter;
        logic out_ld;
    } grc_cmd_t;

    typedef struct packed {
        logic clr_done;
        logic in_cast;
        logic out_bound;
        logic cell_hit;
        logic div_sat;
        logic div_last;
        logic out_free;
    } grc_status_t;

endpackage

>>> rtl/grc_in_if.sv
// Input channel of the raycaster: valid/ready handshake and one item word.
// Depends on grc_pkg for field widths.
interface grc_in_if;
    logic                        valid;
    logic                        ready;
    logic                        command;
    logic [grc_pkg::CELL_W-1:0]  cell_col;
    logic [grc_pkg::CELL_W-1:0]  cell_row;
    logic [grc_pkg::KIND_W-1:0]  cell_kind;
    logic [grc_pkg::COL_W-1:0]   screen_col;

    modport source (output valid, command, cell_col, cell_row, cell_kind, screen_col,
                    input ready);
    modport sink   (input valid, command, cell_col, cell_row, cell_kind, screen_col,
                    output ready);
endinterface

>>> rtl/grc_out_if.sv
// Result channel of the raycaster: valid/ready handshake and one result word.
// Depends on grc_pkg for field widths; ROW_W follows the screen height.
interface grc_out_if #(
    parameter int ROW_W = 9
);
    logic                        valid;
    logic                        ready;
    logic [grc_pkg::COL_W-1:0]   out_col;
    logic [ROW_W-1:0]            slice_top;
    logic [ROW_W-1:0]            slice_bottom;
    logic [grc_pkg::KIND_W-1:0]  hit_kind;
    logic                        side_hit;
    logic                        no_wall;
    logic [7:0]                  red;
    logic [7:0]                  green;
    logic [7:0]                  blue;

    modport source (output valid, out_col, slice_top, slice_bottom, hit_kind, side_hit,
                    no_wall, red, green, blue, input ready);
    modport sink   (input valid, out_col, slice_top, slice_bottom, hit_kind, side_hit,
                    no_wall, red, green, blue, output ready);
endinterface

>>> rtl/grc_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module grc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/grc_ctrl.sv
// Controller state machine of the raycaster: sequences clearing, ray setup,
// the grid walk and the line-height division. Depends on grc_pkg.
module grc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  grc_pkg::grc_status_t st,
    output grc_pkg::grc_cmd_t    cmd
);

    typedef enum logic [12:0] {
        S_CLEAR = 13'b0000000000001,
        S_IDLE  = 13'b0000000000010,
        S_RAY   = 13'b0000000000100,
        S_SUM   = 13'b0000000001000,
        S_INIT  = 13'b0000000010000,
        S_PQ    = 13'b0000000100000,
        S_STEP  = 13'b0000001000000,
        S_CHECK = 13'b0000010000000,
        S_LOOK  = 13'b0000100000000,
        S_DMUL  = 13'b0001000000000,
        S_DCHK  = 13'b0010000000000,
        S_DIV   = 13'b0100000000000,
        S_FIN   = 13'b1000000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr = 1'b1;
                if (st.clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.ld_in = 1'b1;
                    if (st.in_cast)
                    begin
                        state_next = S_RAY;
                    end
                end
            end
            S_RAY:
            begin
                cmd.ray_mul = 1'b1;
                state_next  = S_SUM;
            end
            S_SUM:
            begin
                cmd.ray_sum = 1'b1;
                state_next  = S_INIT;
            end
            S_INIT:
            begin
                cmd.walk_init = 1'b1;
                state_next    = S_PQ;
            end
            S_PQ:
            begin
                cmd.pq_mul = 1'b1;
                state_next = S_STEP;
            end
            S_STEP:
            begin
                cmd.step   = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (st.out_bound)
                begin
                    cmd.nowall_set = 1'b1;
                    state_next     = S_FIN;
                end
                else
                begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                cmd.look = 1'b1;
                if (st.cell_hit)
                begin
                    state_next = S_DMUL;
                end
                else
                begin
                    cmd.step   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_DMUL:
            begin
                cmd.div_mul = 1'b1;
                state_next  = S_DCHK;
            end
            S_DCHK:
            begin
                cmd.div_chk = 1'b1;
                state_next  = st.div_sat ? S_FIN : S_DIV;
            end
            S_DIV:
            begin
                cmd.div_iter = 1'b1;
                if (st.div_last)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (st.out_free)
                begin
                    cmd.out_ld = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

>>> rtl/grc_datapath.sv
// Datapath of the raycaster: configuration registers, ray products, the DDA
// walk registers, a restoring divider and the result register.
// Depends on grc_pkg; drives the map RAM ports.
module grc_datapath #(
    parameter int SCREEN_WIDTH  = 640,
    parameter int SCREEN_HEIGHT = 480,
    parameter int MAP_DIM       = 64,
    localparam int ROW_W        = $clog2(SCREEN_HEIGHT),
    localparam int AW           = $clog2(MAP_DIM * MAP_DIM)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [grc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [grc_pkg::CFG_W-1:0]       cfg_data,
    input  logic                            in_command,
    input  logic [grc_pkg::CELL_W-1:0]      in_cell_col,
    input  logic [grc_pkg::CELL_W-1:0]      in_cell_row,
    input  logic [grc_pkg::KIND_W-1:0]      in_cell_kind,
    input  logic [grc_pkg::COL_W-1:0]       in_screen_col,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [grc_pkg::COL_W-1:0]       out_col,
    output logic [ROW_W-1:0]                out_top,
    output logic [ROW_W-1:0]                out_bottom,
    output logic [grc_pkg::KIND_W-1:0]      out_kind,
    output logic                            out_side,
    output logic                            out_nowall,
    output logic [7:0]                      out_red,
    output logic [7:0]                      out_green,
    output logic [7:0]                      out_blue,
    output logic                            ram_we,
    output logic [AW-1:0]                   ram_waddr,
    output logic [grc_pkg::KIND_W-1:0]      ram_wdata,
    output logic [AW-1:0]                   ram_raddr,
    input  logic [grc_pkg::KIND_W-1:0]      ram_rdata,
    input  grc_pkg::grc_cmd_t               cmd,
    output grc_pkg::grc_status_t            st
);

    localparam int SW_W   = $clog2(SCREEN_WIDTH + 1);
    localparam int CAM_W  = SW_W + 1;
    localparam int RD_W   = SW_W + 18;
    localparam int AX_W   = RD_W - 1;
    localparam int TX_W   = 10 + $clog2(MAP_DIM + 3);
    localparam int PW     = TX_W + AX_W;
    localparam int SH_W   = $clog2(SCREEN_HEIGHT + 1);
    localparam int NUMW   = SH_W + AX_W;
    localparam int DENW   = SW_W + 4 + TX_W;
    localparam int QW     = $clog2(2 * SCREEN_HEIGHT + 1);
    localparam int DIVW   = (NUMW > DENW + QW) ? NUMW : DENW + QW;
    localparam int CNT_W  = $clog2(QW);
    localparam int IW     = $clog2(MAP_DIM);
    localparam int DEPTH  = MAP_DIM * MAP_DIM;
    localparam int MXW    = grc_pkg::MXW;
    localparam logic [TX_W-1:0] CELL_ONE = TX_W'(1024);
    localparam logic [QW-1:0]   LH_MAX   = QW'(2 * SCREEN_HEIGHT);
    localparam logic [QW-1:0]   HALF_H   = QW'(SCREEN_HEIGHT / 2);

    // Configuration registers.
    logic [15:0]                cam_x_reg, cam_y_reg;
    logic signed [15:0]         vdx_reg, vdy_reg, cpx_reg, cpy_reg;
    logic [grc_pkg::GRID_W-1:0] gw_reg, gh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cam_x_reg <= '0;
            cam_y_reg <= '0;
            vdx_reg   <= 16'sd16384;
            vdy_reg   <= '0;
            cpx_reg   <= '0;
            cpy_reg   <= 16'sd10813;
            gw_reg    <= 7'd64;
            gh_reg    <= 7'd64;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                grc_pkg::REG_CAMERA_X:    cam_x_reg <= cfg_data;
                grc_pkg::REG_CAMERA_Y:    cam_y_reg <= cfg_data;
                grc_pkg::REG_VIEW_DIR_X:  vdx_reg   <= $signed(cfg_data);
                grc_pkg::REG_VIEW_DIR_Y:  vdy_reg   <= $signed(cfg_data);
                grc_pkg::REG_CAM_PLANE_X: cpx_reg   <= $signed(cfg_data);
                grc_pkg::REG_CAM_PLANE_Y: cpy_reg   <= $signed(cfg_data);
                grc_pkg::REG_GRID_WIDTH:  gw_reg    <= cfg_data[grc_pkg::GRID_W-1:0];
                grc_pkg::REG_GRID_HEIGHT: gh_reg    <= cfg_data[grc_pkg::GRID_W-1:0];
                default:                  gw_reg    <= gw_reg;
            endcase
        end
    end

    // Clearing pass over the map after reset.
    logic [AW-1:0] clr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (cmd.clr)
        begin
            clr_reg <= clr_reg + AW'(1);
        end
    end

    logic cell_ok;
    assign cell_ok = (MXW'(in_cell_col) < MXW'(MAP_DIM)) && (MXW'(in_cell_row) < MXW'(MAP_DIM));

    always_comb
    begin
        if (cmd.clr)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = cmd.ld_in && (in_command == grc_pkg::CMD_WRITE) && cell_ok;
            ram_waddr = AW'(AW'(in_cell_col) * AW'(MAP_DIM) + AW'(in_cell_row));
            ram_wdata = in_cell_kind;
        end
    end

    // Ray and walk registers.
    logic [grc_pkg::COL_W-1:0]   col_reg;
    logic signed [RD_W-1:0]      pa_reg, pb_reg, pc_reg, pd_reg;
    logic signed [RD_W-1:0]      rdx_reg, rdy_reg;
    logic [AX_W-1:0]             ax_reg, ay_reg;
    logic                        negx_reg, negy_reg;
    logic [TX_W-1:0]             tx_reg, ty_reg, dist_reg;
    logic signed [MXW-1:0]       mx_reg, my_reg;
    logic [PW-1:0]               p_reg, q_reg;
    logic                        side_reg, nowall_reg;
    logic [grc_pkg::KIND_W-1:0]  kind_reg;
    logic [NUMW-1:0]             num_reg;
    logic [DENW-1:0]             den_reg;
    logic [DIVW-1:0]             rem_reg, dsh_reg;
    logic [QW-1:0]               quo_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic                        sat_reg;

    logic signed [RD_W-1:0]      cam_s, sw_s, vdx_s, vdy_s, cpx_s, cpy_s;
    logic signed [RD_W-1:0]      rdx_sum, rdy_sum;
    logic [MXW-1:0]              gw_lim, gh_lim;
    logic                        x_first;
    logic                        sat_now;
    logic [DIVW-1:0]             den_top;

    always_comb
    begin
        cam_s   = RD_W'($signed({1'b0, col_reg, 1'b0})) - RD_W'(SCREEN_WIDTH);
        sw_s    = RD_W'(SCREEN_WIDTH);
        vdx_s   = RD_W'(vdx_reg);
        vdy_s   = RD_W'(vdy_reg);
        cpx_s   = RD_W'(cpx_reg);
        cpy_s   = RD_W'(cpy_reg);
        rdx_sum = pa_reg + pb_reg;
        rdy_sum = pc_reg + pd_reg;
        gw_lim  = (MXW'(gw_reg) > MXW'(MAP_DIM)) ? MXW'(MAP_DIM) : MXW'(gw_reg);
        gh_lim  = (MXW'(gh_reg) > MXW'(MAP_DIM)) ? MXW'(MAP_DIM) : MXW'(gh_reg);
        // An x step only when the x boundary is strictly nearer.
        x_first = p_reg < q_reg;
        den_top = DIVW'(den_reg) << QW;
        sat_now = (dist_reg == '0) || (DIVW'(num_reg) >= den_top);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ld_in)
        begin
            col_reg <= in_screen_col;
        end
        if (cmd.ray_mul)
        begin
            pa_reg <= vdx_s * sw_s;
            pb_reg <= cpx_s * cam_s;
            pc_reg <= vdy_s * sw_s;
            pd_reg <= cpy_s * cam_s;
        end
        if (cmd.ray_sum)
        begin
            rdx_reg <= rdx_sum;
            rdy_reg <= rdy_sum;
        end
        if (cmd.walk_init)
        begin
            negx_reg <= rdx_reg[RD_W-1];
            negy_reg <= rdy_reg[RD_W-1];
            ax_reg   <= rdx_reg[RD_W-1] ? AX_W'(-rdx_reg) : AX_W'(rdx_reg);
            ay_reg   <= rdy_reg[RD_W-1] ? AX_W'(-rdy_reg) : AX_W'(rdy_reg);
            tx_reg   <= rdx_reg[RD_W-1] ? TX_W'(cam_x_reg[9:0])
                                        : CELL_ONE - TX_W'(cam_x_reg[9:0]);
            ty_reg   <= rdy_reg[RD_W-1] ? TX_W'(cam_y_reg[9:0])
                                        : CELL_ONE - TX_W'(cam_y_reg[9:0]);
            mx_reg   <= MXW'(cam_x_reg[15:10]);
            my_reg   <= MXW'(cam_y_reg[15:10]);
        end
        if (cmd.pq_mul)
        begin
            p_reg <= PW'(tx_reg[10:0]) * PW'(ay_reg);
            q_reg <= PW'(ty_reg[10:0]) * PW'(ax_reg);
        end
        if (cmd.step)
        begin
            if (x_first)
            begin
                p_reg    <= p_reg + (PW'(ay_reg) << 10);
                dist_reg <= tx_reg;
                tx_reg   <= tx_reg + CELL_ONE;
                mx_reg   <= negx_reg ? mx_reg - MXW'(1) : mx_reg + MXW'(1);
                side_reg <= 1'b0;
            end
            else
            begin
                q_reg    <= q_reg + (PW'(ax_reg) << 10);
                dist_reg <= ty_reg;
                ty_reg   <= ty_reg + CELL_ONE;
                my_reg   <= negy_reg ? my_reg - MXW'(1) : my_reg + MXW'(1);
                side_reg <= 1'b1;
            end
        end
        if (cmd.look)
        begin
            kind_reg <= ram_rdata;
        end
        if (cmd.div_mul)
        begin
            num_reg <= NUMW'(side_reg ? ay_reg : ax_reg) * NUMW'(SCREEN_HEIGHT);
            den_reg <= DENW'(dist_reg) * DENW'(SCREEN_WIDTH * 16);
        end
        if (cmd.div_chk)
        begin
            sat_reg <= sat_now;
            rem_reg <= DIVW'(num_reg);
            dsh_reg <= DIVW'(den_reg) << (QW - 1);
            quo_reg <= '0;
            cnt_reg <= CNT_W'(QW - 1);
        end
        if (cmd.div_iter)
        begin
            if (rem_reg >= dsh_reg)
            begin
                rem_reg <= rem_reg - dsh_reg;
                quo_reg <= {quo_reg[QW-2:0], 1'b1};
            end
            else
            begin
                quo_reg <= {quo_reg[QW-2:0], 1'b0};
            end
            dsh_reg <= dsh_reg >> 1;
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nowall_reg <= 1'b0;
        end
        else if (cmd.ld_in)
        begin
            nowall_reg <= 1'b0;
        end
        else if (cmd.nowall_set)
        begin
            nowall_reg <= 1'b1;
        end
    end

    assign ram_raddr = AW'(AW'(mx_reg[IW-1:0]) * AW'(MAP_DIM) + AW'(my_reg[IW-1:0]));

    // Result formation.
    logic [QW-1:0]   lh, hh, top_w, bot_w;
    logic [7:0]      r_w, g_w, b_w;

    always_comb
    begin
        if (sat_reg || quo_reg > LH_MAX)
        begin
            lh = LH_MAX;
        end
        else
        begin
            lh = quo_reg;
        end
        hh    = lh >> 1;
        top_w = (HALF_H >= hh) ? HALF_H - hh : '0;
        bot_w = hh + HALF_H;
        if (bot_w >= QW'(SCREEN_HEIGHT))
        begin
            bot_w = QW'(SCREEN_HEIGHT - 1);
        end
        case (kind_reg)
            grc_pkg::KIND_RED:
            begin
                r_w = 8'hFF; g_w = 8'h00; b_w = 8'h00;
            end
            grc_pkg::KIND_GREEN:
            begin
                r_w = 8'h00; g_w = 8'hFF; b_w = 8'h00;
            end
            grc_pkg::KIND_BLUE:
            begin
                r_w = 8'h00; g_w = 8'h00; b_w = 8'hFF;
            end
            default:
            begin
                r_w = 8'hFF; g_w = 8'hFF; b_w = 8'hFF;
            end
        endcase
        if (side_reg)
        begin
            r_w = r_w >> 1;
            g_w = g_w >> 1;
            b_w = b_w >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_ld)
        begin
            out_col    <= col_reg;
            out_nowall <= nowall_reg;
            if (nowall_reg)
            begin
                out_top    <= '0;
                out_bottom <= '0;
                out_kind   <= '0;
                out_side   <= 1'b0;
                out_red    <= '0;
                out_green  <= '0;
                out_blue   <= '0;
            end
            else
            begin
                out_top    <= ROW_W'(top_w);
                out_bottom <= ROW_W'(bot_w);
                out_kind   <= kind_reg;
                out_side   <= side_reg;
                out_red    <= r_w;
                out_green  <= g_w;
                out_blue   <= b_w;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (cmd.out_ld)
        begin
            out_valid <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid <= 1'b0;
        end
    end

    always_comb
    begin
        st.clr_done  = (clr_reg == AW'(DEPTH - 1));
        st.in_cast   = (in_command == grc_pkg::CMD_CAST) &&
                       (int'(in_screen_col) < SCREEN_WIDTH);
        st.out_bound = mx_reg[MXW-1] || my_reg[MXW-1] ||
                       (mx_reg >= $signed(gw_lim)) || (my_reg >= $signed(gh_lim));
        st.cell_hit  = (ram_rdata != '0);
        st.div_sat   = sat_now;
        st.div_last  = (cnt_reg == '0);
        st.out_free  = !out_valid || out_ready;
    end

endmodule

>>> rtl/grid_raycast_column_top.sv
// Top level of the column raycaster: controller, datapath and the map RAM.
// Depends on grc_pkg, grc_in_if, grc_out_if, grc_ram, grc_ctrl, grc_datapath.
//
// Usage. Words arrive on the items channel. A write word (command 0) stores one
// map cell and returns nothing. A cast word (command 1) names a screen column;
// columns at or beyond SCREEN_WIDTH are dropped. For every other cast one result
// word leaves on the results channel.
// The user must write configuration registers on cfg_we/cfg_index/cfg_data only
// while the block is idle; the block itself does not enforce this. They take
// effect on the next cast.
// A cast runs the ray products, their sum, the walk set-up and the boundary products,
// then steps the DDA walk; each step checks the bounds and then looks up the cell
// through the registered read of the map RAM. The walk visits at most about 2*MAP_DIM
// cells. On a hit the divider runs Q = clog2(2*SCREEN_HEIGHT+1) iterations (10 at
// 480 rows), none when the height saturates. Casts are worked one at a time.
// Reset clears the map with one RAM write a cycle, all MAP_DIM*MAP_DIM cells (4096
// by default); no word is taken until it ends. Configuration writes are taken as ever.
// A finished result waits in the output register while the receiver stalls; write
// words are still taken, and the next cast may run up to its result meanwhile.
module grid_raycast_column_top #(
    parameter int SCREEN_WIDTH  = 640,
    parameter int SCREEN_HEIGHT = 480,
    parameter int MAP_DIM       = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [grc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [grc_pkg::CFG_W-1:0]      cfg_data,
    grc_in_if.sink                         items,
    grc_out_if.source                      results
);

    localparam int AW = $clog2(MAP_DIM * MAP_DIM);

    grc_pkg::grc_cmd_t    cmd;
    grc_pkg::grc_status_t st;

    logic                        ram_we;
    logic [AW-1:0]               ram_waddr, ram_raddr;
    logic [grc_pkg::KIND_W-1:0]  ram_wdata, ram_rdata;

    grc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (items.valid),
        .in_ready (items.ready),
        .st       (st),
        .cmd      (cmd)
    );

    grc_datapath #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .MAP_DIM       (MAP_DIM)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_command    (items.command),
        .in_cell_col   (items.cell_col),
        .in_cell_row   (items.cell_row),
        .in_cell_kind  (items.cell_kind),
        .in_screen_col (items.screen_col),
        .out_valid     (results.valid),
        .out_ready     (results.ready),
        .out_col       (results.out_col),
        .out_top       (results.slice_top),
        .out_bottom    (results.slice_bottom),
        .out_kind      (results.hit_kind),
        .out_side      (results.side_hit),
        .out_nowall    (results.no_wall),
        .out_red       (results.red),
        .out_green     (results.green),
        .out_blue      (results.blue),
        .ram_we        (ram_we),
        .ram_waddr     (ram_waddr),
        .ram_wdata     (ram_wdata),
        .ram_raddr     (ram_raddr),
        .ram_rdata     (ram_rdata),
        .cmd           (cmd),
        .st            (st)
    );

    grc_ram #(
        .WIDTH (grc_pkg::KIND_W),
        .DEPTH (MAP_DIM * MAP_DIM)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

>>> rtl/grc_checker.sv
// Port-level checker for the raycaster, bound to the top level.
// Depends on grc_pkg and grid_raycast_column_top_macros.svh.
`include "grid_raycast_column_top_macros.svh"

module grc_checker #(
    parameter int SCREEN_HEIGHT = 480,
    localparam int ROW_W        = $clog2(SCREEN_HEIGHT)
) (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic [grc_pkg::COL_W-1:0]      out_col,
    input logic [ROW_W-1:0]               slice_top,
    input logic [ROW_W-1:0]               slice_bottom,
    input logic                           side_hit,
    input logic                           no_wall,
    input logic [7:0]                     red,
    input logic [7:0]                     green,
    input logic [7:0]                     blue
);

    `GRC_ASSERT_NEXT(a_valid_held, out_valid && !out_ready, out_valid,
                     "result word dropped while stalled")
    `GRC_ASSERT_NEXT(a_col_held, out_valid && !out_ready, $stable(out_col),
                     "stalled result column changed")
    `GRC_ASSERT_NOW(a_nowall_blank, out_valid && no_wall,
                    slice_top == '0 && slice_bottom == '0 && red == 8'h00 &&
                    green == 8'h00 && blue == 8'h00,
                    "no-wall result is not blank")
    `GRC_ASSERT_NOW(a_slice_order, out_valid && !no_wall,
                    slice_top <= slice_bottom && slice_bottom <= ROW_W'(SCREEN_HEIGHT - 1),
                    "wall slice rows out of order")
    `GRC_ASSERT_NOW(a_side_dim, out_valid && side_hit, !red[7] && !green[7] && !blue[7],
                    "side hit colour not halved")

endmodule

bind grid_raycast_column_top grc_checker #(
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
) u_grc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (results.valid),
    .out_ready    (results.ready),
    .out_col      (results.out_col),
    .slice_top    (results.slice_top),
    .slice_bottom (results.slice_bottom),
    .side_hit     (results.side_hit),
    .no_wall      (results.no_wall),
    .red          (results.red),
    .green        (results.green),
    .blue         (results.blue)
);

>>> test/grc_column_checker.sv
`timescale 1ns / 1ps
// Checker for the column raycaster: watches the configuration port and both channels.
// It predicts each cast result and compares it. Depends on grc_pkg, grc_in_if and grc_out_if.
module grc_column_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [grc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [grc_pkg::CFG_W-1:0]     cfg_data,
    grc_in_if                             items,
    grc_out_if                            results,
    output int                            fail_count,
    output int                            pending
);
    import grc_pkg::*;

    localparam longint SCR_W = 640;
    localparam longint SCR_H = 480;
    localparam int     DIM   = 64;

    typedef struct packed {
        logic [9:0] col;
        logic [8:0] top;
        logic [8:0] bottom;
        logic [7:0] kind;
        logic       side;
        logic       nowall;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } slice_t;

    logic [7:0]         cells [0:DIM*DIM-1];
    logic [15:0]        cam_x, cam_y;
    logic signed [15:0] dir_x, dir_y, plane_x, plane_y;
    logic [6:0]         grid_w, grid_h;
    slice_t             slices_due [$];

    function automatic slice_t cast_column(input logic [9:0] col);
        longint cam, rdx, rdy, ax, ay, tx, ty, cross_d, axis, lh, gw, gh, top, bot;
        int     mx, my, sx, sy;
        bit     side, nowall;
        logic [7:0] kind;
        slice_t s;
        side = 0;
        nowall = 0;
        kind = '0;
        cross_d = 0;
        axis = 0;
        cam = 2 * longint'(col) - SCR_W;
        rdx = longint'(dir_x) * SCR_W + longint'(plane_x) * cam;
        rdy = longint'(dir_y) * SCR_W + longint'(plane_y) * cam;
        ax = rdx < 0 ? -rdx : rdx;
        ay = rdy < 0 ? -rdy : rdy;
        gw = grid_w > DIM ? DIM : longint'(grid_w);
        gh = grid_h > DIM ? DIM : longint'(grid_h);
        mx = int'(cam_x[15:10]);
        my = int'(cam_y[15:10]);
        sx = rdx < 0 ? -1 : 1;
        sy = rdy < 0 ? -1 : 1;
        tx = rdx < 0 ? longint'(cam_x[9:0]) : 1024 - longint'(cam_x[9:0]);
        ty = rdy < 0 ? longint'(cam_y[9:0]) : 1024 - longint'(cam_y[9:0]);
        forever
        begin
            // An x step needs the x boundary strictly nearer; ties go to y.
            if (tx * ay < ty * ax)
            begin
                cross_d = tx;
                axis = ax;
                tx += 1024;
                mx += sx;
                side = 0;
            end
            else
            begin
                cross_d = ty;
                axis = ay;
                ty += 1024;
                my += sy;
                side = 1;
            end
            if (mx < 0 || my < 0 || mx >= gw || my >= gh)
            begin
                nowall = 1;
                break;
            end
            kind = cells[mx * DIM + my];
            if (kind != 0)
                break;
        end
        s = '0;
        s.col = col;
        if (nowall)
        begin
            s.nowall = 1'b1;
            return s;
        end
        if (cross_d == 0)
            lh = 2 * SCR_H;
        else
        begin
            lh = (SCR_H * axis) / (SCR_W * 16 * cross_d);
            if (lh > 2 * SCR_H)
                lh = 2 * SCR_H;
        end
        top = SCR_H / 2 - lh / 2;
        if (top < 0)
            top = 0;
        bot = lh / 2 + SCR_H / 2;
        if (bot >= SCR_H)
            bot = SCR_H - 1;
        s.top = top[8:0];
        s.bottom = bot[8:0];
        s.kind = kind;
        s.side = side;
        if (kind == KIND_RED)
            s.red = 8'd255;
        else if (kind == KIND_GREEN)
            s.green = 8'd255;
        else if (kind == KIND_BLUE)
            s.blue = 8'd255;
        else
        begin
            s.red = 8'd255;
            s.green = 8'd255;
            s.blue = 8'd255;
        end
        if (side)
        begin
            s.red = s.red >> 1;
            s.green = s.green >> 1;
            s.blue = s.blue >> 1;
        end
        return s;
    endfunction

    task automatic report_mismatch(input string what, input logic [9:0] col,
                                   input int got, input int want);
        $display("%0t: column %0d %s got %0d expected %0d", $realtime, col, what, got, want);
        fail_count++;
    endtask

    initial
    begin
        fail_count = 0;
        pending = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        slice_t got, want;
        if (!rst_n)
        begin
            foreach (cells[i])
                cells[i] = '0;
            cam_x = '0;
            cam_y = '0;
            dir_x = 16'sd16384;
            dir_y = '0;
            plane_x = '0;
            plane_y = 16'sd10813;
            grid_w = 7'd64;
            grid_h = 7'd64;
            slices_due.delete();
            pending = 0;
        end
        else
        begin
            if (results.valid && results.ready)
            begin
                got = '{results.out_col, results.slice_top, results.slice_bottom,
                        results.hit_kind, results.side_hit, results.no_wall,
                        results.red, results.green, results.blue};
                if (slices_due.size() == 0)
                    report_mismatch("unexpected word", got.col, 1, 0);
                else
                begin
                    want = slices_due.pop_front();
                    if (got.col != want.col)
                        report_mismatch("out_col", want.col, got.col, want.col);
                    if (got.top != want.top)
                        report_mismatch("slice_top", want.col, got.top, want.top);
                    if (got.bottom != want.bottom)
                        report_mismatch("slice_bottom", want.col, got.bottom, want.bottom);
                    if (got.kind != want.kind)
                        report_mismatch("hit_kind", want.col, got.kind, want.kind);
                    if (got.side != want.side)
                        report_mismatch("side_hit", want.col, got.side, want.side);
                    if (got.nowall != want.nowall)
                        report_mismatch("no_wall", want.col, got.nowall, want.nowall);
                    if (got.red != want.red)
                        report_mismatch("red", want.col, got.red, want.red);
                    if (got.green != want.green)
                        report_mismatch("green", want.col, got.green, want.green);
                    if (got.blue != want.blue)
                        report_mismatch("blue", want.col, got.blue, want.blue);
                end
            end
            if (items.valid && items.ready)
            begin
                if (items.command == CMD_WRITE)
                    cells[int'(items.cell_col) * DIM + int'(items.cell_row)] = items.cell_kind;
                else if (items.screen_col < SCR_W)
                    slices_due.push_back(cast_column(items.screen_col));
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_CAMERA_X:    cam_x = cfg_data;
                    REG_CAMERA_Y:    cam_y = cfg_data;
                    REG_VIEW_DIR_X:  dir_x = cfg_data;
                    REG_VIEW_DIR_Y:  dir_y = cfg_data;
                    REG_CAM_PLANE_X: plane_x = cfg_data;
                    REG_CAM_PLANE_Y: plane_y = cfg_data;
                    REG_GRID_WIDTH:  grid_w = cfg_data[6:0];
                    REG_GRID_HEIGHT: grid_h = cfg_data[6:0];
                    default: ;
                endcase
            end
            pending = slices_due.size();
        end
    end
endmodule

>>> test/grid_raycast_column_top_tb.sv
`timescale 1ns / 1ps
// Testbench top for grid_raycast_column_top: clock, reset, stimulus and verdict.
// Depends on grc_pkg, the channel interfaces, the block and grc_column_checker.
module grid_raycast_column_top_tb;
    import grc_pkg::*;

    localparam longint CYCLE_LIMIT = 3000000;
    localparam int     SETTLE      = 400;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    int                   fail_count;
    int                   pending;
    longint               cycles;
    int                   burst_left;
    bit                   no_gaps;

    grc_in_if  items_if ();
    grc_out_if results_if ();

    grid_raycast_column_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .items     (items_if),
        .results   (results_if)
    );

    grc_column_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .items      (items_if),
        .results    (results_if),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #10 clk = ~clk;
    end

    initial
        cycles = 0;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL grid_raycast_column_top");
            $finish;
        end
    end

    // The receiver switches between steady acceptance, coin-toss stalls and long stalls.
    initial
    begin
        int mode, left;
        results_if.ready <= 1'b0;
        mode = 0;
        left = 0;
        forever
        begin
            @(negedge clk);
            if (left == 0)
            begin
                mode = $urandom_range(0, 2);
                left = $urandom_range(5, 200);
            end
            left--;
            case (mode)
                0: results_if.ready <= 1'b1;
                1: results_if.ready <= 1'($urandom_range(0, 1));
                default: results_if.ready <= ($urandom_range(0, 15) == 0);
            endcase
        end
    end

    task automatic send_word(input logic cmd, input logic [5:0] ccol, input logic [5:0] crow,
                             input logic [7:0] kind, input logic [9:0] scol);
        if (burst_left == 0)
        begin
            if (!no_gaps)
            begin
                items_if.valid <= 1'b0;
                repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20)) @(negedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        items_if.valid      <= 1'b1;
        items_if.command    <= cmd;
        items_if.cell_col   <= ccol;
        items_if.cell_row   <= crow;
        items_if.cell_kind  <= kind;
        items_if.screen_col <= scol;
        @(posedge clk);
        while (!items_if.ready)
            @(posedge clk);
        @(negedge clk);
        burst_left--;
    endtask

    task automatic write_cell(input int x, input int y, input int kind);
        send_word(CMD_WRITE, x[5:0], y[5:0], kind[7:0], '0);
    endtask

    task automatic cast(input int scol);
        send_word(CMD_CAST, 6'($urandom), 6'($urandom), 8'($urandom), scol[9:0]);
    endtask

    // Drops valid and waits for every result, then for the settling time.
    task automatic settle();
        items_if.valid <= 1'b0;
        burst_left = 0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic set_regs(input logic [15:0] cx, input logic [15:0] cy,
                            input logic [15:0] dx, input logic [15:0] dy,
                            input logic [15:0] px, input logic [15:0] py,
                            input logic [6:0] gw, input logic [6:0] gh);
        logic [15:0] vals [8];
        vals = '{cx, cy, dx, dy, px, py, {9'd0, gw}, {9'd0, gh}};
        for (int i = 0; i < 8; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= i[CFG_IDX_W-1:0];
            cfg_data  <= vals[i];
            @(negedge clk);
        end
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    function automatic int wall_kind();
        case ($urandom_range(0, 4))
            0: return KIND_RED;
            1: return KIND_GREEN;
            2: return KIND_BLUE;
            3: return 0;
            default: return $urandom_range(1, 255);
        endcase
    endfunction

    function automatic logic [15:0] any_dir();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'h7FFF;
            2: return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    initial
    begin
        int gw, gh, eff_w, eff_h, walls;
        rst_n               = 1'b0;
        cfg_we              <= 1'b0;
        cfg_index           <= '0;
        cfg_data            <= '0;
        items_if.valid      <= 1'b0;
        items_if.command    <= CMD_WRITE;
        items_if.cell_col   <= '0;
        items_if.cell_row   <= '0;
        items_if.cell_kind  <= '0;
        items_if.screen_col <= '0;
        burst_left = 0;
        no_gaps = 0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // Reset settings, first on an empty map where every ray leaves the grid.
        cast(0);
        cast(639);
        cast(640);
        cast(1023);
        write_cell(63, 63, 255);
        write_cell(0, 0, 0);
        write_cell(5, 0, KIND_RED);
        write_cell(5, 1, KIND_GREEN);
        write_cell(4, 2, KIND_BLUE);
        write_cell(3, 3, 77);
        cast(320);
        cast(0);
        cast(639);
        settle();

        // Camera exactly on a cell boundary looking back: zero crossing distance.
        set_regs(16'h0800, 16'h0A00, 16'hC000, 16'h0000, 16'h0000, 16'd10813, 7'd64, 7'd64);
        write_cell(1, 2, KIND_RED);
        cast(320);
        cast(100);
        write_cell(2, 1, KIND_GREEN);
        cast(600);
        settle();

        // Ray straight along y with a zero x component, on a narrow grid.
        set_regs(16'h0600, 16'h0400, 16'h0000, 16'h4000, 16'h0000, 16'h0000, 7'd2, 7'd6);
        write_cell(1, 4, KIND_BLUE);
        cast(320);
        cast(1);
        settle();

        for (int phase = 0; phase < 12; phase++)
        begin
            no_gaps = (phase % 4 == 3);
            case (phase)
                0:       begin gw = 64;  gh = 64;  end
                1:       begin gw = 1;   gh = 1;   end
                2:       begin gw = 127; gh = 100; end
                3:       begin gw = 0;   gh = 33;  end
                default: begin gw = $urandom_range(3, 20); gh = $urandom_range(3, 20); end
            endcase
            eff_w = gw > 64 ? 64 : (gw < 1 ? 1 : gw);
            eff_h = gh > 64 ? 64 : (gh < 1 ? 1 : gh);
            if (phase == 0)
                set_regs(16'hFFFF, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000,
                         gw[6:0], gh[6:0]);
            else if (phase == 5)
                set_regs(16'($urandom), 16'($urandom), any_dir(), any_dir(), any_dir(),
                         any_dir(), gw[6:0], gh[6:0]);
            else
                set_regs(16'($urandom_range(0, eff_w * 1024 - 1)),
                         16'($urandom_range(0, eff_h * 1024 - 1)),
                         any_dir(), any_dir(), any_dir(), any_dir(), gw[6:0], gh[6:0]);

            // Lay walls inside the grid in use, then mix casts with further edits.
            walls = $urandom_range(15, 30);
            for (int i = 0; i < walls; i++)
                write_cell($urandom_range(0, eff_w - 1), $urandom_range(0, eff_h - 1),
                           wall_kind());
            for (int i = 0; i < 110 - walls; i++)
            begin
                case ($urandom_range(0, 9))
                    0:       write_cell($urandom_range(0, 63), $urandom_range(0, 63),
                                        $urandom_range(0, 255));
                    1:       write_cell($urandom_range(0, eff_w - 1),
                                        $urandom_range(0, eff_h - 1), wall_kind());
                    2:       cast($urandom_range(640, 1023));
                    default: cast($urandom_range(0, 639));
                endcase
            end
            settle();
        end

        if (fail_count == 0)
            $display("PASS grid_raycast_column_top");
        else
            $display("FAIL grid_raycast_column_top");
        $finish;
    end
endmodule

>>> sim.f
+incdir+rtl
rtl/grc_pkg.sv
rtl/grc_in_if.sv
rtl/grc_out_if.sv
rtl/grc_ram.sv
rtl/grc_ctrl.sv
rtl/grc_datapath.sv
rtl/grid_raycast_column_top.sv
rtl/grc_checker.sv
test/grc_column_checker.sv
test/grid_raycast_column_top_tb.sv
